FILE: rtl/sfrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfrc_pkg;

	localparam int COST_CEILING_DEF = 252;
	localparam int FRAC_BITS_DEF    = 16;

	// configuration register indexes
	localparam logic REG_URGENCY = 1'b0;
	localparam logic REG_AVOID   = 1'b1;

	typedef struct packed {
		logic [7:0] cval;
		logic       first;
		logic       last;
		logic       free;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WGT,
		ST_CHK,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/sfrc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sfrc_front import sfrc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] cell_value,
	input  wire logic       first_cell,
	input  wire logic       last_cell,
	output logic            deq_valid,
	output item_t           deq_item,
	input  wire logic       deq_pop
);

	item_t       mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign deq_valid = (cnt_q != 2'd0);
	assign deq_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q].cval  <= cell_value;
			mem_q[wr_q].first <= first_cell;
			mem_q[wr_q].last  <= last_cell;
			mem_q[wr_q].free  <= (cell_value == 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (deq_pop) rd_q <= ~rd_q;
			case ({push, deq_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (rd_q == wr_q))
		else $error("queue pointers disagree with count");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		deq_pop |-> deq_valid) else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/sfrc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sfrc_back import sfrc_pkg::*; #(
	parameter int COST_CEILING = COST_CEILING_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [3:0] urgency,
	input  wire logic [6:0] avoid,
	input  wire logic       deq_valid,
	input  wire item_t      deq_item,
	output logic            deq_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      cell_out,
	output logic [7:0]      region_cost,
	output logic            region_done
);

	localparam int MW   = FRAC_BITS + 1;
	localparam int OW   = 12;
	localparam int PW   = OW + MW;
	localparam int SW   = FRAC_BITS + 16;
	localparam int WW   = FRAC_BITS + 3;
	localparam int DW   = FRAC_BITS + 6;
	localparam int WMIN = ((1 << FRAC_BITS) - 1) / 1000000;
	localparam logic [MW-1:0] ONE   = MW'(1) << FRAC_BITS;
	localparam logic [OW-1:0] CAP10 = OW'(10 * COST_CEILING);
	localparam logic [7:0]    CEIL  = 8'(COST_CEILING);

	function automatic logic [MW-1:0] qand(input logic [2:0] q, input logic [MW-1:0] m);
		logic [MW+2:0] p;
		p = (MW+3)'(q) * (MW+3)'(m) + (MW+3)'(2);
		return MW'(p >> 2);
	endfunction

	// avoidance membership ramps, n/50 and n/20 rounded half up
	logic [MW-1:0] t50 [51];
	logic [MW-1:0] t20 [21];
	for (genvar n = 0; n <= 50; n++) begin : g_t50
		localparam logic [MW-1:0] V = MW'(((n << FRAC_BITS) + 25) / 50);
		assign t50[n] = V;
	end
	for (genvar n = 0; n <= 20; n++) begin : g_t20
		localparam logic [MW-1:0] V = MW'(((n << FRAC_BITS) + 10) / 20);
		assign t20[n] = V;
	end

	// memberships; urgency ones are held as quarters
	logic [3:0]    u_cl;
	logic [6:0]    v_cl;
	logic [2:0]    ql, qm, qh;
	logic [MW-1:0] al, am, ah;
	logic [2:0]    ql_q, qm_q, qh_q;
	logic [MW-1:0] al_q, am_q, ah_q;

	always_comb begin
		u_cl = (urgency > 4'd10) ? 4'd10 : urgency;
		v_cl = (avoid > 7'd100) ? 7'd100 : avoid;
		ql = 3'd0;
		qm = 3'd0;
		qh = 3'd0;
		if (u_cl <= 4'd1) ql = 3'd4;
		else if (u_cl < 4'd5) ql = 3'(4'd5 - u_cl);
		if (u_cl > 4'd1 && u_cl < 4'd9)
			qm = (u_cl <= 4'd5) ? 3'(u_cl - 4'd1) : 3'(4'd9 - u_cl);
		if (u_cl >= 4'd9) qh = 3'd4;
		else if (u_cl > 4'd5) qh = 3'(u_cl - 4'd5);
		al = '0;
		am = '0;
		ah = '0;
		if (v_cl <= 7'd20) al = ONE;
		else if (v_cl < 7'd70) al = t50[6'(7'd70 - v_cl)];
		if (v_cl >= 7'd20 && v_cl <= 7'd90)
			am = (v_cl <= 7'd70) ? t50[6'(v_cl - 7'd20)] : t20[5'(7'd90 - v_cl)];
		if (v_cl >= 7'd90) ah = ONE;
		else if (v_cl >= 7'd70) ah = t20[5'(v_cl - 7'd70)];
	end

	always_ff @(posedge clk) begin
		ql_q <= ql;
		qm_q <= qm;
		qh_q <= qh;
		al_q <= al;
		am_q <= am;
		ah_q <= ah;
	end

	state_t        state_q, state_d;
	logic          found_q;
	logic [7:0]    held_q;
	logic [7:0]    c_q;
	logic          last_q;
	logic [2:0]    rule_q;
	logic [MW-1:0] w_s1;
	logic [OW-1:0] o_s1;
	logic [SW-1:0] s_q;
	logic [WW-1:0] wsum_q;
	logic [SW-1:0] rem_q;
	logic [2:0]    bit_q;
	logic [7:0]    quo_q;
	logic          out_vld_q;
	logic [7:0]    cell_out_q, region_q;
	logic          done_q;

	logic          slot_free;
	logic          eff_found;
	logic [7:0]    eff_held;
	logic          start, emit_direct, emit_rated;
	logic [MW-1:0] wt;
	logic [OW-1:0] ov;
	logic [12:0]   c18, c15;
	logic [DW-1:0] dval;
	logic [SW-1:0] dsh;
	logic [7:0]    capped;
	logic [PW-1:0] prod;

	assign slot_free = !out_vld_q || out_ready;
	assign eff_found = deq_item.first ? 1'b0 : found_q;
	assign eff_held  = deq_item.first ? 8'd0 : held_q;
	assign dval      = DW'(wsum_q) * DW'(10);
	assign dsh       = SW'(dval) << bit_q;
	assign capped    = (quo_q > CEIL) ? CEIL : quo_q;
	assign prod      = PW'(o_s1) * PW'(w_s1);

	always_comb begin
		c18 = 13'(c_q) * 13'd18;
		c15 = 13'(c_q) * 13'd15;
		case (rule_q)
			3'd0: begin wt = ah_q;                 ov = (c18 < 13'(CAP10)) ? OW'(c18) : CAP10; end
			3'd1: begin wt = qand(ql_q, am_q);      ov = (c15 < 13'(CAP10)) ? OW'(c15) : CAP10; end
			3'd2: begin wt = qand(qh_q, ONE - ah_q); ov = OW'(c_q) * OW'(2); end
			3'd3: begin wt = qand(qm_q, al_q);      ov = OW'(c_q) * OW'(5); end
			3'd4: begin wt = qand(qm_q, am_q);      ov = OW'(c_q) * OW'(10); end
			3'd5: begin wt = qand(ql_q, al_q);      ov = OW'(c_q) * OW'(10); end
			default: begin wt = '0; ov = '0; end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		deq_pop     = 1'b0;
		start       = 1'b0;
		emit_direct = 1'b0;
		emit_rated  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (deq_valid && slot_free) begin
					deq_pop = 1'b1;
					if (!deq_item.free && !eff_found) begin
						start   = 1'b1;
						state_d = ST_WGT;
					end else begin
						emit_direct = 1'b1;
					end
				end
			end
			ST_WGT:  if (rule_q == 3'd6) state_d = ST_CHK;
			ST_CHK: begin
				if (wsum_q <= WW'(WMIN) || s_q >= (SW'(dval) << 8)) state_d = ST_EMIT;
				else state_d = ST_DIV;
			end
			ST_DIV:  if (bit_q == 3'd0) state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free) begin
					emit_rated = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			found_q   <= 1'b0;
			held_q    <= 8'd0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (deq_pop) begin
				found_q <= eff_found;
				held_q  <= eff_held;
			end
			if (emit_rated) begin
				found_q <= 1'b1;
				held_q  <= capped;
			end
			if (emit_direct || emit_rated) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			c_q    <= deq_item.cval;
			last_q <= deq_item.last;
			rule_q <= 3'd0;
			s_q    <= '0;
			wsum_q <= '0;
		end
		if (state_q == ST_WGT) begin
			rule_q <= rule_q + 3'd1;
			w_s1   <= wt;
			o_s1   <= ov;
			// accumulate the rule taken on the previous step
			if (rule_q != 3'd0) begin
				s_q    <= s_q + SW'(prod);
				wsum_q <= wsum_q + WW'(w_s1);
			end
		end
		if (state_q == ST_CHK) begin
			rem_q <= s_q;
			bit_q <= 3'd7;
			if (wsum_q <= WW'(WMIN)) quo_q <= 8'd0;
			else if (s_q >= (SW'(dval) << 8)) quo_q <= CEIL;
			else quo_q <= 8'd0;
		end
		if (state_q == ST_DIV) begin
			bit_q <= bit_q - 3'd1;
			if (rem_q >= dsh) begin
				rem_q        <= rem_q - dsh;
				quo_q[bit_q] <= 1'b1;
			end
		end
		if (emit_direct) begin
			cell_out_q <= deq_item.free ? 8'd0 : eff_held;
			region_q   <= eff_held;
			done_q     <= deq_item.last;
		end
		if (emit_rated) begin
			cell_out_q <= capped;
			region_q   <= capped;
			done_q     <= last_q;
		end
	end

	assign out_valid   = out_vld_q;
	assign cell_out    = cell_out_q;
	assign region_cost = region_q;
	assign region_done = done_q;

	a_held_cap: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CEIL) else $error("held cost above ceiling");
	a_unfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> (held_q == 8'd0)) else $error("cost held without rating");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < (SW'(dval) << ({1'b0, bit_q} + 4'd1))))
		else $error("remainder out of range");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_EMIT))
		else $error("result raised outside issue or emit");

endmodule

`default_nettype wire

FILE: rtl/sugeno_fuzzy_region_cost_unit.sv
// Fuzzy region cost unit. Cells of a costmap region stream in on the input
// channel, one result per cell leaves on the output channel in order. Free
// cells and cells of a region whose cost is already rated pass at one per
// cycle while the output is not stalled, through the input queue and the
// output register. The first non-free cell of a region is rated by the
// back-end sequencer: an issue step, seven weight and accumulate steps, one
// range check, eight restoring divide steps (skipped when the weight sum is
// zero or the quotient overflows eight bits) and one emit, while a two-entry
// queue keeps taking input until full. Configuration writes pass through
// registers before use and belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none

module sugeno_fuzzy_region_cost_unit import sfrc_pkg::*; #(
	parameter int COST_CEILING = COST_CEILING_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_addr,
	input  wire logic [6:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] cell_value,
	input  wire logic       first_cell,
	input  wire logic       last_cell,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      cell_out,
	output logic [7:0]      region_cost,
	output logic            region_done
);

	logic [3:0] urgency_q;
	logic [6:0] avoid_q;
	logic       deq_valid;
	logic       deq_pop;
	item_t      deq_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			urgency_q <= 4'd0;
			avoid_q   <= 7'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_URGENCY: urgency_q <= cfg_wdata[3:0];
				REG_AVOID:   avoid_q   <= cfg_wdata;
				default:     urgency_q <= urgency_q;
			endcase
		end
	end

	sfrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_value (cell_value),
		.first_cell (first_cell),
		.last_cell  (last_cell),
		.deq_valid  (deq_valid),
		.deq_item   (deq_item),
		.deq_pop    (deq_pop)
	);

	sfrc_back #(
		.COST_CEILING (COST_CEILING),
		.FRAC_BITS    (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.urgency     (urgency_q),
		.avoid       (avoid_q),
		.deq_valid   (deq_valid),
		.deq_item    (deq_item),
		.deq_pop     (deq_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_out    (cell_out),
		.region_cost (region_cost),
		.region_done (region_done)
	);

endmodule

`default_nettype wire

FILE: bench/sugeno_fuzzy_region_cost_unit_test.sv
`timescale 1ns / 1ps

module sugeno_fuzzy_region_cost_unit_test;
	import sfrc_pkg::*;

	localparam int CEIL = COST_CEILING_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam longint unsigned ONE = 64'd1 << FB;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [7:0] cval;
		logic [7:0] cost;
		logic       done;
	} cell_result_t;

	class region_cost_board;
		logic [3:0] urgency;
		logic [6:0] avoid;
		bit found;
		logic [7:0] held;
		cell_result_t pending[$];
		int errors;

		function void clear();
			urgency = 0;
			avoid = 0;
			found = 0;
			held = 0;
			errors = 0;
			pending.delete();
		endfunction

		function longint unsigned ratio(longint unsigned num, longint unsigned den);
			return ((num << FB) + den / 2) / den;
		endfunction

		function longint unsigned fand(longint unsigned a, longint unsigned b);
			return (a * b + ONE / 2) >> FB;
		endfunction

		function longint unsigned cap(longint unsigned x);
			return x < CEIL * 10 ? x : CEIL * 10;
		endfunction

		function logic [7:0] rate(longint unsigned c);
			longint unsigned u, v, ul, um, uh, al, am, ah, s, ws, q;
			longint unsigned w[6];
			longint unsigned o[6];
			u = urgency > 10 ? 10 : urgency;
			v = avoid > 100 ? 100 : avoid;
			ul = 0; um = 0; uh = 0; al = 0; am = 0; ah = 0;
			if (u <= 1) ul = ONE;
			else if (u < 5) ul = ratio(5 - u, 4);
			if (u > 1 && u < 9) um = (u <= 5) ? ratio(u - 1, 4) : ratio(9 - u, 4);
			if (u >= 9) uh = ONE;
			else if (u > 5) uh = ratio(u - 5, 4);
			if (v <= 20) al = ONE;
			else if (v < 70) al = ratio(70 - v, 50);
			if (v >= 20 && v <= 90) am = (v <= 70) ? ratio(v - 20, 50) : ratio(90 - v, 20);
			if (v >= 90) ah = ONE;
			else if (v >= 70) ah = ratio(v - 70, 20);
			w[0] = ah;
			w[1] = fand(am, ul);
			w[2] = fand(uh, ONE - ah);
			w[3] = fand(um, al);
			w[4] = fand(um, am);
			w[5] = fand(ul, al);
			o[0] = cap(c * 18);
			o[1] = cap(c * 15);
			o[2] = c * 2;
			o[3] = c * 5;
			o[4] = c * 10;
			o[5] = c * 10;
			s = 0;
			ws = 0;
			for (int k = 0; k < 6; k++) begin
				s += o[k] * w[k];
				ws += w[k];
			end
			if (ws * 1000000 < ONE) return 0;
			q = s / (ws * 10);
			if (q > CEIL) q = CEIL;
			return q[7:0];
		endfunction

		function void note_cell(logic [7:0] c, logic f, logic l);
			cell_result_t r;
			if (f) begin
				found = 0;
				held = 0;
			end
			r.cval = 0;
			if (c != 0) begin
				if (!found) begin
					held = rate(c);
					found = 1;
				end
				r.cval = held;
			end
			r.cost = held;
			r.done = l;
			pending.push_back(r);
		endfunction

		function void check_result(logic [7:0] c, logic [7:0] rc, logic d);
			cell_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result cell_out=%0d", c);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (c !== e.cval) begin
				$error("cell_out expected %0d actual %0d", e.cval, c);
				errors++;
			end
			if (rc !== e.cost) begin
				$error("region_cost expected %0d actual %0d", e.cost, rc);
				errors++;
			end
			if (d !== e.done) begin
				$error("region_done expected %0d actual %0d", e.done, d);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_addr = REG_URGENCY;
	logic [6:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [7:0] cell_value = 0;
	logic first_cell = 0;
	logic last_cell = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [7:0] cell_out, region_cost;
	logic region_done;

	region_cost_board board;
	int idle_cycles = 0;
	bit hold_off = 0;
	bit sink_on = 0;

	always #5 clk = ~clk;

	sugeno_fuzzy_region_cost_unit dut (.*);

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_reg(logic idx, logic [6:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_URGENCY) board.urgency = val[3:0];
		else board.avoid = val;
		@(posedge clk);
	endtask

	// valid stays up after a transfer until the next call or drain replaces it
	task automatic send_cell(logic [7:0] c, logic f, logic l, bit gaps);
		int g;
		g = gaps ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		cell_value <= c;
		first_cell <= f;
		last_cell <= l;
		do @(posedge clk); while (!in_ready);
		board.note_cell(c, f, l);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic random_region(bit gaps);
		int n;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			logic [7:0] c;
			c = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
			if ($urandom_range(0, 20) == 0) c = 8'hff;
			send_cell(c, i == 0 ? 1'b1 : ($urandom_range(0, 15) == 0),
				i == n - 1 ? 1'b1 : ($urandom_range(0, 15) == 0), gaps);
		end
	endtask

	// sink: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (sink_on && out_valid && out_ready)
			board.check_result(cell_out, region_cost, region_done);
		if (!sink_on || hold_off) out_ready <= 0;
		else out_ready <= ($urandom_range(0, 99) < 70) ||
			($urandom_range(0, 99) < 50);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("sugeno_fuzzy_region_cost_unit regression: fail");
			$finish;
		end
	end

	initial begin
		logic [3:0] urg[6];
		logic [6:0] avd[7];
		int sent;
		urg = '{0, 15, 10, 3, 7, 5};
		avd = '{0, 127, 100, 45, 80, 20, 90};
		board = new();
		board.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		sink_on <= 1;
		write_reg(REG_URGENCY, 0);
		write_reg(REG_AVOID, 0);

		// directed: extremes and region special cases
		send_cell(0, 1, 0, 0);
		send_cell(0, 0, 1, 0);
		send_cell(255, 1, 0, 0);
		send_cell(1, 0, 0, 0);
		send_cell(0, 0, 1, 0);
		send_cell(7, 0, 1, 0);
		send_cell(1, 1, 1, 0);
		drain();
		write_reg(REG_URGENCY, 15);
		write_reg(REG_AVOID, 127);
		send_cell(255, 1, 0, 0);
		send_cell(128, 0, 1, 0);
		send_cell(1, 1, 1, 0);
		drain();
		write_reg(REG_URGENCY, 7);
		write_reg(REG_AVOID, 45);
		send_cell(200, 1, 0, 0);
		send_cell(0, 0, 0, 0);
		send_cell(9, 0, 1, 0);
		drain();

		// pressure: sink held off while cells keep coming
		hold_off <= 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off <= 0;
			end
			begin
				for (int i = 0; i < 20; i++) send_cell(8'($urandom_range(1, 255)),
					i % 5 == 0, i % 5 == 4, 0);
				in_valid <= 0;
				@(posedge clk);
			end
		join
		drain();

		sent = 0;
		while (sent < 700) begin
			int cnt;
			write_reg(REG_URGENCY, 7'($urandom_range(0, 3) == 0 ? urg[$urandom_range(0, 5)]
				: 4'($urandom)));
			write_reg(REG_AVOID, $urandom_range(0, 3) == 0 ? avd[$urandom_range(0, 6)]
				: 7'($urandom));
			cnt = $urandom_range(5, 12);
			for (int r = 0; r < cnt; r++) begin
				random_region($urandom_range(0, 4) != 0);
				sent += 6;
			end
			drain();
		end

		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("sugeno_fuzzy_region_cost_unit regression: pass");
		else
			$display("sugeno_fuzzy_region_cost_unit regression: fail");
		$finish;
	end

endmodule

FILE: sugeno_fuzzy_region_cost_unit.f
rtl/sfrc_pkg.sv
rtl/sfrc_front.sv
rtl/sfrc_back.sv
rtl/sugeno_fuzzy_region_cost_unit.sv
bench/sugeno_fuzzy_region_cost_unit_test.sv
